// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock while out of reset
`define SVNG_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("svng assertion failed");

// same-cycle implication
`define SVNG_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("svng implication failed");

// next-cycle implication
`define SVNG_ASSERT_NXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("svng next-cycle check failed");

`endif

// ===== rtl/svng_pkg.sv =====
// types and constants of the sphere vertex normal generator
`default_nettype none

package svng_pkg;

   localparam int unsigned TABLE_LIMIT      = 240;
   localparam int unsigned NORMAL_FRAC_BITS = 14;
   localparam int unsigned RADIUS_W         = 16;
   localparam int unsigned COUNT_W          = 8;
   localparam int unsigned VERTEX_W         = 17;
   localparam int unsigned NORMAL_W         = NORMAL_FRAC_BITS + 2;

   localparam logic [COUNT_W-1:0] SLICE_CLAMP = COUNT_W'(TABLE_LIMIT - 2);
   localparam logic [COUNT_W-1:0] STACK_CLAMP = COUNT_W'(TABLE_LIMIT - 1);

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
   localparam logic [COUNT_W-1:0]  SLICE_RESET  = 8'd16;
   localparam logic [COUNT_W-1:0]  STACK_RESET  = 8'd16;

   // angle numerator and denominator, up to 4 * stacks
   localparam int unsigned ANGLE_W  = 10;
   localparam int unsigned PHASE_W  = 32;
   localparam int unsigned TRIG_W   = 24;
   localparam int unsigned DIV_BITS = 4;
   localparam int unsigned DIV_STAGES   = PHASE_W / DIV_BITS;
   localparam int unsigned HORNER_STEPS = 6;
   localparam int unsigned SIN_STEPS    = 5;
   localparam int unsigned TRIG_LAT     = DIV_STAGES + 3 + 2 * HORNER_STEPS + 1;

   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

   // divide by constant as multiply by reciprocal, exact below 2^30
   localparam int unsigned SIN_SHIFT [SIN_STEPS] = '{37, 37, 36, 35, 33};
   localparam logic [31:0] SIN_M [SIN_STEPS] = '{
      32'((64'd1 << 37) / 110 + 1),
      32'((64'd1 << 37) / 72 + 1),
      32'((64'd1 << 36) / 42 + 1),
      32'((64'd1 << 35) / 20 + 1),
      32'((64'd1 << 33) / 6 + 1)
   };
   localparam int unsigned COS_SHIFT [HORNER_STEPS] = '{38, 37, 36, 35, 34, 31};
   localparam logic [31:0] COS_M [HORNER_STEPS] = '{
      32'((64'd1 << 38) / 132 + 1),
      32'((64'd1 << 37) / 90 + 1),
      32'((64'd1 << 36) / 56 + 1),
      32'((64'd1 << 35) / 30 + 1),
      32'((64'd1 << 34) / 12 + 1),
      32'((64'd1 << 31) / 2 + 1)
   };

   typedef enum logic [1:0] {
      OP_TOP    = 2'd0,
      OP_BOTTOM = 2'd1,
      OP_BAND   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_RADIUS = 2'd0,
      CSR_SLICES = 2'd1,
      CSR_STACKS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_pair_type;

endpackage

`default_nettype wire

// ===== rtl/svng_if.sv =====
// channel interfaces of the sphere vertex normal generator
`default_nettype none

interface svng_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] band_row;
   logic [7:0] position;
   logic       lower_edge;

   modport source (output valid, operation, band_row, position, lower_edge, input ready);
   modport sink (input valid, operation, band_row, position, lower_edge, output ready);
endinterface

interface svng_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] vertex_x;
   logic signed [16:0] vertex_y;
   logic signed [16:0] vertex_z;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               index_ok;

   modport source (output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                   normal_z, index_ok, input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                 normal_z, index_ok, output ready);
endinterface

interface svng_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/svng_trig.sv =====
// pipelined sine and cosine of a fraction of a turn
`default_nettype none

module svng_trig (
   input  logic                             clock,
   input  logic                             advance,
   input  logic [svng_pkg::ANGLE_W-1:0]     num,
   input  logic [svng_pkg::ANGLE_W-1:0]     den,
   output svng_pkg::trig_pair_type          result
);

   localparam int unsigned AW = svng_pkg::ANGLE_W;
   localparam int unsigned DS = svng_pkg::DIV_STAGES;
   localparam int unsigned HS = 2 * svng_pkg::HORNER_STEPS;

   // long division, DIV_BITS quotient bits per stage
   function automatic logic [AW+svng_pkg::PHASE_W-1:0] div_step(
      input logic [AW-1:0]               rem,
      input logic [AW-1:0]               dv,
      input logic [AW-2:0]               half,
      input logic [svng_pkg::PHASE_W-1:0] quo,
      input logic [4:0]                  top
   );
      logic [AW:0]                 r;
      logic [svng_pkg::PHASE_W-1:0] q;
      logic [svng_pkg::PHASE_W-1:0] lo;
      logic [4:0]                  b;
      r  = {1'b0, rem};
      q  = quo;
      lo = svng_pkg::PHASE_W'(half);
      for (int k = 0; k < svng_pkg::DIV_BITS; k++) begin
         b = top - 5'(k);
         r = {r[AW-1:0], lo[b]};
         if (r >= {1'b0, dv}) begin
            r    = r - {1'b0, dv};
            q[b] = 1'b1;
         end
      end
      return {r[AW-1:0], q};
   endfunction

   logic [AW-1:0]                rem_ff  [DS];
   logic [AW-1:0]                rem_in  [DS];
   logic [AW-1:0]                den_ff  [DS];
   logic [AW-1:0]                den_in  [DS];
   logic [AW-2:0]                half_ff [DS];
   logic [AW-2:0]                half_in [DS];
   logic [svng_pkg::PHASE_W-1:0] quo_ff  [DS];
   logic [svng_pkg::PHASE_W-1:0] quo_in  [DS];

   always_comb begin
      logic [AW-1:0]                r_src;
      logic [AW-1:0]                d_src;
      logic [AW-2:0]                h_src;
      logic [svng_pkg::PHASE_W-1:0] q_src;
      logic [AW+svng_pkg::PHASE_W-1:0] res;
      for (int g = 0; g < DS; g++) begin
         if (g == 0) begin
            r_src = num;
            d_src = den;
            h_src = den[AW-1:1];
            q_src = '0;
         end else begin
            r_src = rem_ff[g-1];
            d_src = den_ff[g-1];
            h_src = half_ff[g-1];
            q_src = quo_ff[g-1];
         end
         res = div_step(r_src, d_src, h_src, q_src,
                        5'(svng_pkg::PHASE_W - 1 - svng_pkg::DIV_BITS * g));
         rem_in[g]  = res[AW+svng_pkg::PHASE_W-1:svng_pkg::PHASE_W];
         quo_in[g]  = res[svng_pkg::PHASE_W-1:0];
         den_in[g]  = d_src;
         half_in[g] = h_src;
      end
   end

   // octant fold, radians, square
   logic [29:0] phase_r;
   logic        fold_big;
   logic [29:0] fold_in;
   logic [1:0]  fq_ff;
   logic        fbig_ff;
   logic [29:0] rr_ff;
   logic [63:0] x_prod;
   logic [29:0] x_in;
   logic [1:0]  xq_ff;
   logic        xbig_ff;
   logic [29:0] x_ff;
   logic [63:0] x2_prod;
   logic [29:0] x2_in;
   logic [1:0]  x2q_ff;
   logic        x2big_ff;
   logic [29:0] xc_ff;
   logic [29:0] x2_ff;

   assign phase_r  = quo_ff[DS-1][29:0];
   assign fold_big = phase_r > 30'h2000_0000;
   assign fold_in  = fold_big ? 30'(31'h4000_0000 - {1'b0, phase_r}) : phase_r;
   assign x_prod   = 64'(rr_ff) * 64'(svng_pkg::TWO_PI_Q30) + 64'h8000_0000;
   assign x_in     = 30'(x_prod >> 32);
   assign x2_prod  = 64'(x_ff) * 64'(x_ff);
   assign x2_in    = 30'(x2_prod >> 30);

   // horner steps: even stage multiplies, odd stage divides and subtracts
   logic [30:0] ts_ff   [HS];
   logic [30:0] ts_in   [HS];
   logic [30:0] tc_ff   [HS];
   logic [30:0] tc_in   [HS];
   logic [29:0] hx_ff   [HS];
   logic [29:0] hx_in   [HS];
   logic [29:0] hx2_ff  [HS];
   logic [29:0] hx2_in  [HS];
   logic [1:0]  hq_ff   [HS];
   logic [1:0]  hq_in   [HS];
   logic        hbig_ff [HS];
   logic        hbig_in [HS];

   always_comb begin
      logic [30:0] ts;
      logic [30:0] tc;
      logic [29:0] xv;
      logic [29:0] x2v;
      logic [63:0] ps;
      logic [63:0] pc;
      int          k;
      for (int n = 0; n < HS; n++) begin
         k = n >> 1;
         if (n == 0) begin
            ts         = svng_pkg::Q30_ONE;
            tc         = svng_pkg::Q30_ONE;
            xv         = xc_ff;
            x2v        = x2_ff;
            hq_in[n]   = x2q_ff;
            hbig_in[n] = x2big_ff;
         end else begin
            ts         = ts_ff[n-1];
            tc         = tc_ff[n-1];
            xv         = hx_ff[n-1];
            x2v        = hx2_ff[n-1];
            hq_in[n]   = hq_ff[n-1];
            hbig_in[n] = hbig_ff[n-1];
         end
         hx_in[n]  = xv;
         hx2_in[n] = x2v;
         if ((n & 1) == 0) begin
            if (k == svng_pkg::HORNER_STEPS - 1) begin
               ps = 64'(xv) * 64'(ts);
            end else begin
               ps = 64'(x2v) * 64'(ts);
            end
            pc       = 64'(x2v) * 64'(tc);
            ts_in[n] = 31'(ps >> 30);
            tc_in[n] = 31'(pc >> 30);
         end else begin
            ps = 64'(ts) * 64'(svng_pkg::SIN_M[(k < svng_pkg::SIN_STEPS) ? k : 0]);
            pc = 64'(tc) * 64'(svng_pkg::COS_M[k]);
            if (k < svng_pkg::SIN_STEPS) begin
               ts_in[n] = svng_pkg::Q30_ONE
                  - 31'(ps >> svng_pkg::SIN_SHIFT[(k < svng_pkg::SIN_STEPS) ? k : 0]);
            end else begin
               ts_in[n] = ts;
            end
            tc_in[n] = svng_pkg::Q30_ONE - 31'(pc >> svng_pkg::COS_SHIFT[k]);
         end
      end
   end

   // octant swap, round to q2.22, quadrant signs
   logic [30:0]                       s0;
   logic [30:0]                       c0;
   logic signed [svng_pkg::TRIG_W-1:0] ms;
   logic signed [svng_pkg::TRIG_W-1:0] mc;
   svng_pkg::trig_pair_type           res_in;
   svng_pkg::trig_pair_type           res_ff;

   assign s0 = hbig_ff[HS-1] ? tc_ff[HS-1] : ts_ff[HS-1];
   assign c0 = hbig_ff[HS-1] ? ts_ff[HS-1] : tc_ff[HS-1];
   assign ms = svng_pkg::TRIG_W'((32'(s0) + 32'd128) >> 8);
   assign mc = svng_pkg::TRIG_W'((32'(c0) + 32'd128) >> 8);

   always_comb begin
      case (hq_ff[HS-1])
         2'd0: begin
            res_in.sin_val = ms;
            res_in.cos_val = mc;
         end
         2'd1: begin
            res_in.sin_val = mc;
            res_in.cos_val = -ms;
         end
         2'd2: begin
            res_in.sin_val = -ms;
            res_in.cos_val = -mc;
         end
         default: begin
            res_in.sin_val = -mc;
            res_in.cos_val = ms;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int g = 0; g < DS; g++) begin
            rem_ff[g]  <= rem_in[g];
            den_ff[g]  <= den_in[g];
            half_ff[g] <= half_in[g];
            quo_ff[g]  <= quo_in[g];
         end
         fq_ff    <= quo_ff[DS-1][31:30];
         fbig_ff  <= fold_big;
         rr_ff    <= fold_in;
         xq_ff    <= fq_ff;
         xbig_ff  <= fbig_ff;
         x_ff     <= x_in;
         x2q_ff   <= xq_ff;
         x2big_ff <= xbig_ff;
         xc_ff    <= x_ff;
         x2_ff    <= x2_in;
         for (int n = 0; n < HS; n++) begin
            ts_ff[n]   <= ts_in[n];
            tc_ff[n]   <= tc_in[n];
            hx_ff[n]   <= hx_in[n];
            hx2_ff[n]  <= hx2_in[n];
            hq_ff[n]   <= hq_in[n];
            hbig_ff[n] <= hbig_in[n];
         end
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/sphere_vertex_normal_generator.sv =====
// uv sphere vertex and face normal generator, top level
// throughput: one request per cycle while the pipe advances
// the 24-stage divide and polynomial trig pipe sets depth
// the whole pipe holds while a result beat waits and is not taken
// reset sets radius 1.0, 16 slices and 16 stacks and empties the pipe
`default_nettype none
`include "assert_macros.svh"

module sphere_vertex_normal_generator (
   input  logic            clock,
   input  logic            reset,
   svng_req_if.sink        req_if,
   svng_rsp_if.source      rsp_if,
   svng_csr_if.sink        csr_if
);

   localparam int unsigned LAT = svng_pkg::TRIG_LAT;
   localparam int unsigned NSH = 44 - svng_pkg::NORMAL_FRAC_BITS;

   typedef struct packed {
      logic valid;
      logic ok;
      logic apex;
      logic neg;
      logic sbz;
   } side_type;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
      logic [63:0] m;
      logic [63:0] r;
      m = (v < 0) ? 64'(-v) : 64'(v);
      r = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -$signed(r) : $signed(r);
   endfunction

   // configuration
   logic [15:0] radius_ff;
   logic [7:0]  slice_count_ff;
   logic [7:0]  stack_count_ff;

   assign csr_if.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= svng_pkg::RADIUS_RESET;
         slice_count_ff <= svng_pkg::SLICE_RESET;
         stack_count_ff <= svng_pkg::STACK_RESET;
      end else if (csr_if.valid) begin
         case (svng_pkg::csr_index_type'(csr_if.index))
            svng_pkg::CSR_RADIUS: radius_ff <= csr_if.data;
            svng_pkg::CSR_SLICES: begin
               slice_count_ff <= (csr_if.data[7:0] >= 8'(svng_pkg::TABLE_LIMIT))
                  ? svng_pkg::SLICE_CLAMP : csr_if.data[7:0];
            end
            svng_pkg::CSR_STACKS: begin
               stack_count_ff <= (csr_if.data[7:0] >= 8'(svng_pkg::TABLE_LIMIT))
                  ? svng_pkg::STACK_CLAMP : csr_if.data[7:0];
            end
            default: ;
         endcase
      end
   end

   // pipe advance
   logic out_valid_ff;
   logic advance;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance && !reset;

   // request decode
   logic        d_ok;
   logic        d_apex;
   logic [7:0]  d_i;
   logic [7:0]  d_jv;
   logic [7:0]  d_jn;
   logic [9:0]  n0, d0, n1, d1, n2, d2, n3, d3;
   side_type    side_in;

   always_comb begin
      logic [7:0] sc;
      logic [7:0] kc;
      sc     = slice_count_ff;
      kc     = stack_count_ff;
      d_ok   = 1'b0;
      d_apex = 1'b0;
      d_i    = '0;
      d_jv   = '0;
      d_jn   = 8'd1;
      if (sc >= 8'd2 && kc >= 8'd1) begin
         case (svng_pkg::op_type'(req_if.operation))
            svng_pkg::OP_TOP: begin
               if (req_if.position == 8'd0) begin
                  d_ok   = 1'b1;
                  d_apex = 1'b1;
               end else if ({1'b0, req_if.position} <= {1'b0, sc} + 9'd1) begin
                  d_ok = 1'b1;
                  d_i  = 8'({1'b0, sc} + 9'd1 - {1'b0, req_if.position});
                  d_jv = 8'd1;
                  d_jn = 8'd1;
               end
            end
            svng_pkg::OP_BOTTOM: begin
               if (req_if.position == 8'd0) begin
                  d_ok   = 1'b1;
                  d_apex = 1'b1;
               end else if ({1'b0, req_if.position} <= {1'b0, sc} + 9'd1) begin
                  d_ok = 1'b1;
                  d_i  = req_if.position - 8'd1;
                  d_jv = kc - 8'd1;
                  d_jn = kc;
               end
            end
            svng_pkg::OP_BAND: begin
               if (kc >= 8'd3 && req_if.band_row >= 8'd1 && req_if.band_row <= kc - 8'd2
                   && req_if.position <= sc) begin
                  d_ok = 1'b1;
                  d_i  = req_if.position;
                  d_jv = req_if.lower_edge ? req_if.band_row : req_if.band_row + 8'd1;
                  d_jn = req_if.band_row + 8'd1;
               end
            end
            default: ;
         endcase
      end
      n0 = (d_i == sc) ? 10'd0 : {2'b0, d_i};
      d0 = {2'b0, sc};
      n1 = {2'b0, d_jv};
      d1 = {1'b0, kc, 1'b0};
      n2 = (d_i == 8'd0) ? {1'b0, sc, 1'b0} - 10'd1 : {1'b0, d_i, 1'b0} - 10'd1;
      d2 = {1'b0, sc, 1'b0};
      n3 = {1'b0, d_jn, 1'b0} - 10'd1;
      d3 = {kc, 2'b00};
      side_in.valid = req_if.valid;
      side_in.ok    = d_ok;
      side_in.apex  = d_apex;
      side_in.neg   = (svng_pkg::op_type'(req_if.operation) == svng_pkg::OP_BOTTOM);
      side_in.sbz   = (d_jv == 8'd0) || (d_jv == kc);
   end

   // four angle units in parallel
   svng_pkg::trig_pair_type slice_v, ring_v, slice_n, ring_n;

   svng_trig u_trig_slice_v (.clock(clock), .advance(advance), .num(n0), .den(d0),
                             .result(slice_v));
   svng_trig u_trig_ring_v (.clock(clock), .advance(advance), .num(n1), .den(d1),
                            .result(ring_v));
   svng_trig u_trig_slice_n (.clock(clock), .advance(advance), .num(n2), .den(d2),
                             .result(slice_n));
   svng_trig u_trig_ring_n (.clock(clock), .advance(advance), .num(n3), .den(d3),
                            .result(ring_n));

   side_type side_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) begin
            side_ff[s] <= '0;
         end
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // stage p1: radius and normal products
   side_type           p1_side_ff;
   logic signed [23:0] sa_ff, ca_ff, cb3_ff;
   logic signed [40:0] rs_ff, rc_ff;
   logic signed [47:0] npx_ff, npy_ff;
   logic signed [23:0] sb_sel;
   logic signed [16:0] rad_s;

   assign sb_sel = side_ff[LAT-1].sbz ? 24'sd0 : ring_v.sin_val;
   assign rad_s  = signed'({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_ff  <= slice_v.sin_val;
         ca_ff  <= slice_v.cos_val;
         cb3_ff <= ring_n.cos_val;
         rs_ff  <= 41'(rad_s) * 41'(sb_sel);
         rc_ff  <= 41'(rad_s) * 41'(ring_v.cos_val);
         npx_ff <= 48'(slice_n.sin_val) * 48'(ring_n.sin_val);
         npy_ff <= 48'(slice_n.cos_val) * 48'(ring_n.sin_val);
      end
   end

   // stage p2: partial vertex products and normal rounding
   side_type           p2_side_ff;
   logic signed [44:0] pxl_ff, pxh_ff, pyl_ff, pyh_ff;
   logic signed [16:0] vz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [20:0] rs_lo;
   logic signed [20:0] rs_hi;

   assign rs_lo = signed'({1'b0, rs_ff[19:0]});
   assign rs_hi = $signed(rs_ff[40:20]);

   always_ff @(posedge clock) begin
      if (advance) begin
         pxl_ff <= 45'(rs_lo) * 45'(sa_ff);
         pxh_ff <= 45'(rs_hi) * 45'(sa_ff);
         pyl_ff <= 45'(rs_lo) * 45'(ca_ff);
         pyh_ff <= 45'(rs_hi) * 45'(ca_ff);
         vz_ff  <= 17'(rnd(64'(rc_ff), 22));
         nx_ff  <= 16'(rnd(64'(npx_ff), NSH));
         ny_ff  <= 16'(rnd(64'(npy_ff), NSH));
         nz_ff  <= 16'(rnd(64'(cb3_ff), NSH - 22));
      end
   end

   // stage p3: vertex sums
   side_type           p3_side_ff;
   logic signed [61:0] sx_ff, sy_ff;
   logic signed [16:0] vz3_ff;
   logic signed [15:0] nx3_ff, ny3_ff, nz3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff  <= (62'(pxh_ff) <<< 20) + 62'(pxl_ff);
         sy_ff  <= (62'(pyh_ff) <<< 20) + 62'(pyl_ff);
         vz3_ff <= vz_ff;
         nx3_ff <= nx_ff;
         ny3_ff <= ny_ff;
         nz3_ff <= nz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_side_ff <= '0;
         p2_side_ff <= '0;
         p3_side_ff <= '0;
      end else if (advance) begin
         p1_side_ff <= side_ff[LAT-1];
         p2_side_ff <= p1_side_ff;
         p3_side_ff <= p2_side_ff;
      end
   end

   // output register
   logic signed [16:0] vx_in, vy_in, vz_in;
   logic signed [15:0] nx_in, ny_in, nz_in;
   logic signed [16:0] vx_ff, vy_ff, vz_out_ff;
   logic signed [15:0] nx_out_ff, ny_out_ff, nz_out_ff;
   logic               ok_ff;

   always_comb begin
      vx_in = '0;
      vy_in = '0;
      vz_in = '0;
      nx_in = '0;
      ny_in = '0;
      nz_in = '0;
      if (p3_side_ff.ok && p3_side_ff.apex) begin
         vz_in = p3_side_ff.neg ? -signed'({1'b0, radius_ff}) : signed'({1'b0, radius_ff});
         nz_in = p3_side_ff.neg ? -16'sd1 <<< svng_pkg::NORMAL_FRAC_BITS
                                : 16'sd1 <<< svng_pkg::NORMAL_FRAC_BITS;
      end else if (p3_side_ff.ok) begin
         vx_in = 17'(rnd(64'(sx_ff), 44));
         vy_in = 17'(rnd(64'(sy_ff), 44));
         vz_in = vz3_ff;
         nx_in = nx3_ff;
         ny_in = ny3_ff;
         nz_in = nz3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= p3_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff     <= vx_in;
         vy_ff     <= vy_in;
         vz_out_ff <= vz_in;
         nx_out_ff <= nx_in;
         ny_out_ff <= ny_in;
         nz_out_ff <= nz_in;
         ok_ff     <= p3_side_ff.ok;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.vertex_x = vx_ff;
   assign rsp_if.vertex_y = vy_ff;
   assign rsp_if.vertex_z = vz_out_ff;
   assign rsp_if.normal_x = nx_out_ff;
   assign rsp_if.normal_y = ny_out_ff;
   assign rsp_if.normal_z = nz_out_ff;
   assign rsp_if.index_ok = ok_ff;

   // assertion terms
   logic counts_in_range;
   logic reject_beat;
   logic reject_fields_zero;
   logic req_fire;

   assign counts_in_range    = slice_count_ff < 8'(svng_pkg::TABLE_LIMIT)
                               && stack_count_ff < 8'(svng_pkg::TABLE_LIMIT);
   assign reject_beat        = rsp_if.valid && !rsp_if.index_ok;
   assign reject_fields_zero = rsp_if.vertex_x == '0 && rsp_if.vertex_z == '0
                               && rsp_if.normal_z == '0;
   assign req_fire           = req_if.valid && req_if.ready;

   `SVNG_ASSERT(a_count_clamp, counts_in_range)
   `SVNG_ASSERT_IMP(a_reject_zero, reject_beat, reject_fields_zero)
   `SVNG_ASSERT_NXT(a_beat_enters, req_fire, side_ff[0].valid)

endmodule

`default_nettype wire
